// ===== src/extent_range_cache_assert.svh =====
// ----------------------------------------------------------------------------
// Extent range cache assertion macros
// Shared concurrent assertion forms for the extent range cache.
// ----------------------------------------------------------------------------
`ifndef EXTENT_RANGE_CACHE_ASSERT_SVH
`define EXTENT_RANGE_CACHE_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define ERC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ERC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/erc_pkg.sv =====
// ----------------------------------------------------------------------------
// Extent range cache package
// Sizes, codes, word types and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erc_pkg;

    localparam int ENTRIES     = 16;
    localparam int ALIGN_SHIFT = 12;
    localparam int MAX_LENGTH  = 2097152;
    localparam int ADDR_BITS   = 48;

    localparam int ADDR_W = 48;
    localparam int LEN_W  = 22;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // Bits of an address that are kept, and bits that must be zero for alignment.
    localparam logic [ADDR_W-1:0] ADDR_KEEP =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'(1) << ADDR_BITS) - 64'(1));
    localparam logic [ADDR_W-1:0] ALIGN_A = ADDR_W'((64'(1) << ALIGN_SHIFT) - 64'(1));
    localparam logic [LEN_W-1:0]  ALIGN_L = LEN_W'((64'(1) << ALIGN_SHIFT) - 64'(1));
    localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_LENGTH);

    // Action codes.
    localparam logic [2:0] ACT_FIND   = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_FIRST  = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISS     = 3'd1,
        ST_COVERED  = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_BAD      = 3'd4,
        ST_FULL     = 3'd5,
        ST_TRIMMED  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        SHOW_NONE,
        SHOW_HIT,
        SHOW_WORK
    } t_show;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_SCAN_OFF,
        DP_SCAN_MIN,
        DP_DROP_K,
        DP_CLEAR,
        DP_EXTEND,
        DP_INSERT,
        DP_SCAN_EVICT,
        DP_SCAN_TOFF,
        DP_APPLY_OFF,
        DP_SCAN_TMAP,
        DP_APPLY_MAP,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] offset;
        logic [LEN_W-1:0]  length;
        logic              dirty_flag;
        logic [ADDR_W-1:0] map_addr;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] out_offset;
        logic [LEN_W-1:0]  out_length;
        logic              out_dirty;
        logic [ADDR_W-1:0] out_map_addr;
        logic [4:0]        extent_count;
    } t_out_word;

    typedef struct packed {
        t_dp_op  op;
        t_status st;
        t_show   show;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic replace;
        logic mismatch;
        logic covered;
        logic bad;
        logic full;
        logic cut;
        logic out_free;
    } t_stat;

endpackage

// ===== src/erc_dp.sv =====
// ----------------------------------------------------------------------------
// Extent range cache datapath
// Extent table, scan unit, working extent and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "extent_range_cache_assert.svh"

module erc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  erc_pkg::t_in_word  i_in,
    input  erc_pkg::t_cmd      i_cmd,
    input  logic               i_out_stall,
    output erc_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output erc_pkg::t_out_word o_out
);
    import erc_pkg::*;

    // Extent table.
    logic [ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]  r_e_off   [ENTRIES];
    logic [LEN_W-1:0]   r_e_len   [ENTRIES];
    logic               r_e_dirty [ENTRIES];
    logic [ADDR_W-1:0]  r_e_map   [ENTRIES];
    logic [CNT_W-1:0]   r_count;

    // Work registers.
    t_in_word          r_in;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_n;
    logic              r_found;
    logic [ADDR_W-1:0] r_hit_off;
    logic [LEN_W-1:0]  r_hit_len;
    logic              r_hit_dirty;
    logic [ADDR_W-1:0] r_hit_map;
    logic [ADDR_W-1:0] r_w_off;
    logic [LEN_W-1:0]  r_w_len;
    logic              r_w_dirty;
    logic [ADDR_W-1:0] r_w_map;
    logic [ADDR_W-1:0] r_best;
    logic              r_cut;
    logic              r_out_valid;
    t_out_word         r_out;

    t_in_word          ld_in;
    logic [IDX_W-1:0]  n_j;
    logic              s_valid;
    logic [ADDR_W-1:0] s_off;
    logic [LEN_W-1:0]  s_len;
    logic              s_dirty;
    logic [ADDR_W-1:0] s_map;
    logic              look_match;
    logic              evict_match;
    logic              toff_cand;
    logic              tmap_cand;
    logic              min_cand;
    logic              scan_last;
    logic [IDX_W-1:0]  free_idx;
    logic              cut_off;
    logic              cut_map;
    logic [LEN_W-1:0]  len_off;
    logic [LEN_W-1:0]  len_map;
    logic              out_free;

    // Incoming word with addresses cut to the kept width.
    always_comb begin
        ld_in          = i_in;
        ld_in.offset   = i_in.offset & ADDR_KEEP;
        ld_in.map_addr = i_in.map_addr & ADDR_KEEP;
    end

    // Entry under the scan pointer.
    assign s_valid = r_valid[r_j];
    assign s_off   = r_e_off[r_j];
    assign s_len   = r_e_len[r_j];
    assign s_dirty = r_e_dirty[r_j];
    assign s_map   = r_e_map[r_j];

    assign scan_last = (r_j == IDX_W'(ENTRIES - 1));
    assign n_j       = scan_last ? '0 : r_j + IDX_W'(1);

    // Scan compares.
    assign look_match = s_valid && (s_off <= r_in.offset) &&
        ((ADDR_W+1)'(r_in.offset) < (ADDR_W+1)'(s_off) + (ADDR_W+1)'(s_len));
    assign evict_match = s_valid && (r_j != r_n) && (s_map <= r_w_map) &&
        ((ADDR_W+1)'(r_w_map) < (ADDR_W+1)'(s_map) + (ADDR_W+1)'(s_len));
    assign toff_cand = s_valid && (r_j != r_n) && (s_off > r_w_off) &&
        (!r_found || s_off < r_best);
    assign tmap_cand = s_valid && (r_j != r_n) && (s_map > r_w_map) &&
        (!r_found || s_map < r_best);
    assign min_cand = s_valid && (!r_found || s_off < r_hit_off);

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Trim against the nearest successor found by the last scan.
    assign cut_off = r_found &&
        ((ADDR_W+1)'(r_w_off) + (ADDR_W+1)'(r_w_len) > (ADDR_W+1)'(r_best));
    assign len_off = LEN_W'(r_best - r_w_off);
    assign cut_map = r_found &&
        ((ADDR_W+1)'(r_w_map) + (ADDR_W+1)'(r_w_len) > (ADDR_W+1)'(r_best));
    assign len_map = LEN_W'(r_best - r_w_map);

    assign out_free = !r_out_valid || !i_out_stall;

    // Status toward the controller.
    always_comb begin
        o_stat.scan_last = scan_last;
        o_stat.found     = r_found;
        o_stat.replace   = r_found && (r_hit_off == r_in.offset) &&
                           (r_in.length > r_hit_len) && (r_in.map_addr != r_hit_map);
        o_stat.mismatch  = r_hit_off != r_in.offset;
        o_stat.covered   = r_in.length <= r_hit_len;
        o_stat.bad       = ((r_in.offset & ALIGN_A) != '0) ||
                           ((r_in.length & ALIGN_L) != '0) ||
                           (r_in.length == '0) || (r_in.length > MAX_LEN);
        o_stat.full      = &r_valid;
        o_stat.cut       = r_cut;
        o_stat.out_free  = out_free;
    end

    // Control state of the table and scan unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_j         <= '0;
            r_found     <= 1'b0;
            r_cut       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new word fills the output register; a taken word leaves it.
            if (i_cmd.op == DP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_cut   <= 1'b0;
                end
                DP_SCAN_OFF: begin
                    r_j <= n_j;
                    if (look_match && !r_found) begin
                        r_found <= 1'b1;
                    end
                end
                DP_SCAN_MIN, DP_SCAN_TOFF, DP_SCAN_TMAP: begin
                    r_j <= n_j;
                    if ((i_cmd.op == DP_SCAN_MIN && min_cand) ||
                        (i_cmd.op == DP_SCAN_TOFF && toff_cand) ||
                        (i_cmd.op == DP_SCAN_TMAP && tmap_cand)) begin
                        r_found <= 1'b1;
                    end
                end
                DP_DROP_K: begin
                    r_valid[r_k] <= 1'b0;
                    r_count      <= r_count - CNT_W'(1);
                    r_j          <= '0;
                    r_found      <= 1'b0;
                end
                DP_CLEAR: begin
                    r_valid <= '0;
                    r_count <= '0;
                end
                DP_EXTEND: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                end
                DP_INSERT: begin
                    r_valid[free_idx] <= 1'b1;
                    r_count           <= r_count + CNT_W'(1);
                    r_j               <= '0;
                    r_found           <= 1'b0;
                end
                DP_SCAN_EVICT: begin
                    r_j <= n_j;
                    if (evict_match) begin
                        r_valid[r_j] <= 1'b0;
                        r_count      <= r_count - CNT_W'(1);
                    end
                end
                DP_APPLY_OFF, DP_APPLY_MAP: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                    if ((i_cmd.op == DP_APPLY_OFF && cut_off) ||
                        (i_cmd.op == DP_APPLY_MAP && cut_map)) begin
                        r_cut <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload: table contents, captured extents and the output word.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_in <= ld_in;
            end
            DP_SCAN_OFF, DP_SCAN_MIN: begin
                if ((i_cmd.op == DP_SCAN_OFF && look_match && !r_found) ||
                    (i_cmd.op == DP_SCAN_MIN && min_cand)) begin
                    r_k         <= r_j;
                    r_hit_off   <= s_off;
                    r_hit_len   <= s_len;
                    r_hit_dirty <= s_dirty;
                    r_hit_map   <= s_map;
                end
            end
            DP_SCAN_TOFF: begin
                if (toff_cand) begin
                    r_best <= s_off;
                end
            end
            DP_SCAN_TMAP: begin
                if (tmap_cand) begin
                    r_best <= s_map;
                end
            end
            DP_EXTEND: begin
                r_n          <= r_k;
                r_e_len[r_k] <= r_in.length;
                r_w_off      <= r_hit_off;
                r_w_len      <= r_in.length;
                r_w_dirty    <= r_hit_dirty;
                r_w_map      <= r_hit_map;
            end
            DP_INSERT: begin
                r_n                 <= free_idx;
                r_e_off[free_idx]   <= r_in.offset;
                r_e_len[free_idx]   <= r_in.length;
                r_e_dirty[free_idx] <= r_in.dirty_flag;
                r_e_map[free_idx]   <= r_in.map_addr;
                r_w_off             <= r_in.offset;
                r_w_len             <= r_in.length;
                r_w_dirty           <= r_in.dirty_flag;
                r_w_map             <= r_in.map_addr;
            end
            DP_APPLY_OFF: begin
                if (cut_off) begin
                    r_w_len <= len_off;
                end
            end
            DP_APPLY_MAP: begin
                // The final length goes back to the table here.
                if (cut_map) begin
                    r_w_len      <= len_map;
                    r_e_len[r_n] <= len_map;
                end else begin
                    r_e_len[r_n] <= r_w_len;
                end
            end
            DP_OUT: begin
                r_out.status       <= i_cmd.st;
                r_out.extent_count <= 5'(r_count);
                unique case (i_cmd.show)
                    SHOW_HIT: begin
                        r_out.out_offset   <= r_hit_off;
                        r_out.out_length   <= r_hit_len;
                        r_out.out_dirty    <= r_hit_dirty;
                        r_out.out_map_addr <= r_hit_map;
                    end
                    SHOW_WORK: begin
                        r_out.out_offset   <= r_w_off;
                        r_out.out_length   <= r_w_len;
                        r_out.out_dirty    <= r_w_dirty;
                        r_out.out_map_addr <= r_w_map;
                    end
                    default: begin
                        r_out.out_offset   <= '0;
                        r_out.out_length   <= '0;
                        r_out.out_dirty    <= 1'b0;
                        r_out.out_map_addr <= '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The count always matches the valid bits.
    `ERC_ASSERT_ALWAYS(a_count_match, i_clk, i_rst_n, $countones(r_valid) == int'(r_count), "count differs from valid bits")
    `ERC_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.op == DP_CLEAR, r_valid == '0, "clear left valid entries")
    `ERC_ASSERT_NEXT(a_insert_sets, i_clk, i_rst_n, i_cmd.op == DP_INSERT && !(&r_valid), r_valid[r_n], "inserted slot not valid")

endmodule

// ===== src/erc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Extent range cache controller
// Sequences table scans and updates for each action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [2:0]     i_action,
    input  erc_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output erc_pkg::t_cmd  o_cmd
);
    import erc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_CHK,
        S_LOOK,
        S_LOOK_DEC,
        S_INSERT,
        S_EVICT,
        S_TRIM1,
        S_APPLY1,
        S_TRIM2,
        S_APPLY2,
        S_ADD_DONE,
        S_MIN,
        S_MIN_DEC,
        S_CLEAR,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_act, n_act;
    t_status    r_st, n_st;
    t_show      r_show, n_show;

    // Next state and command for the datapath.
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_st      = r_st;
        n_show    = r_show;
        o_cmd.op   = DP_IDLE;
        o_cmd.st   = r_st;
        o_cmd.show = r_show;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_act    = i_action;
                    n_st     = ST_OK;
                    n_show   = SHOW_NONE;
                    priority case (i_action)
                        ACT_FIND, ACT_REMOVE: n_state = S_LOOK;
                        ACT_ADD:              n_state = S_ADD_CHK;
                        ACT_FIRST:            n_state = S_MIN;
                        ACT_CLEAR:            n_state = S_CLEAR;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_ADD_CHK: begin
                if (i_stat.bad) begin
                    n_st    = ST_BAD;
                    n_state = S_OUT;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.op = DP_SCAN_OFF;
                if (i_stat.scan_last) begin
                    n_state = S_LOOK_DEC;
                end
            end
            S_LOOK_DEC: begin
                priority if (r_act == ACT_FIND) begin
                    n_st    = i_stat.found ? ST_OK : ST_MISS;
                    n_show  = i_stat.found ? SHOW_HIT : SHOW_NONE;
                    n_state = S_OUT;
                end else if (r_act == ACT_REMOVE) begin
                    if (i_stat.found) begin
                        o_cmd.op = DP_DROP_K;
                    end
                    n_st    = i_stat.found ? ST_OK : ST_MISS;
                    n_state = S_OUT;
                end else if (!i_stat.found) begin
                    if (i_stat.full) begin
                        n_st    = ST_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_INSERT;
                    end
                end else if (i_stat.replace) begin
                    // Old extent goes, then the lookup runs again.
                    o_cmd.op = DP_DROP_K;
                    n_state  = S_LOOK;
                end else if (i_stat.mismatch) begin
                    n_st    = ST_MISMATCH;
                    n_state = S_OUT;
                end else if (i_stat.covered) begin
                    n_st    = ST_COVERED;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = DP_EXTEND;
                    n_state  = S_TRIM1;
                end
            end
            S_INSERT: begin
                o_cmd.op = DP_INSERT;
                n_state  = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.op = DP_SCAN_EVICT;
                if (i_stat.scan_last) begin
                    n_state = S_TRIM1;
                end
            end
            S_TRIM1: begin
                o_cmd.op = DP_SCAN_TOFF;
                if (i_stat.scan_last) begin
                    n_state = S_APPLY1;
                end
            end
            S_APPLY1: begin
                o_cmd.op = DP_APPLY_OFF;
                n_state  = S_TRIM2;
            end
            S_TRIM2: begin
                o_cmd.op = DP_SCAN_TMAP;
                if (i_stat.scan_last) begin
                    n_state = S_APPLY2;
                end
            end
            S_APPLY2: begin
                o_cmd.op = DP_APPLY_MAP;
                n_state  = S_ADD_DONE;
            end
            S_ADD_DONE: begin
                n_st    = i_stat.cut ? ST_TRIMMED : ST_OK;
                n_show  = SHOW_WORK;
                n_state = S_OUT;
            end
            S_MIN: begin
                o_cmd.op = DP_SCAN_MIN;
                if (i_stat.scan_last) begin
                    n_state = S_MIN_DEC;
                end
            end
            S_MIN_DEC: begin
                n_st    = i_stat.found ? ST_OK : ST_MISS;
                n_show  = i_stat.found ? SHOW_HIT : SHOW_NONE;
                n_state = S_OUT;
            end
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // Wait for room in the output register.
                if (i_stat.out_free) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_FIND;
            r_st    <= ST_OK;
            r_show  <= SHOW_NONE;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_st    <= n_st;
            r_show  <= n_show;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/extent_range_cache.sv =====
// ----------------------------------------------------------------------------
// Extent range cache
// Bounded table of non-overlapping extents with find, add, remove, first
// and clear actions.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | word
//   in      | input     | i_in_valid / o_in_stall   | i_in  (t_in_word)
//   out     | output    | o_out_valid / i_out_stall | o_out (t_out_word)
//
// One word at a time: a new word is accepted only after the previous one's
// result has been written to the output register. Table scans use the single
// scan port that walks the 16-entry table one entry per cycle; an add that
// replaces an extent scans again, and a stalled output register holds the
// cache until the result word can be written.
// Reset is synchronous and empties the table at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module extent_range_cache (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  erc_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output erc_pkg::t_out_word o_out
);
    import erc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    erc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in.action),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Table and datapath.
    erc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== tb/sv/tb_extent_range_cache.sv =====
// ----------------------------------------------------------------------------
// Extent range cache testbench
// Drives find, add, remove, first and clear words into the cache, keeps its
// own model of the extent table, and checks every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: shadow extent table plus the queue of expected output words.
class extent_scoreboard;
    bit          ent_valid [erc_pkg::ENTRIES];
    bit [47:0]   ent_off   [erc_pkg::ENTRIES];
    bit [21:0]   ent_len   [erc_pkg::ENTRIES];
    bit          ent_dirty [erc_pkg::ENTRIES];
    bit [47:0]   ent_map   [erc_pkg::ENTRIES];
    int          live_count;
    erc_pkg::t_out_word pending_words[$];
    int          errors;

    function new();
        for (int i = 0; i < erc_pkg::ENTRIES; i++) ent_valid[i] = 0;
        live_count = 0;
        errors = 0;
    endfunction

    function int lookup(bit [47:0] x);
        for (int i = 0; i < erc_pkg::ENTRIES; i++) begin
            if (ent_valid[i] && ent_off[i] <= x &&
                {16'd0, x} < {16'd0, ent_off[i]} + 64'(ent_len[i]))
                return i;
        end
        return -1;
    endfunction

    function void drop(int i);
        ent_valid[i] = 0;
        live_count--;
    endfunction

    // Shorten extent n so it ends before its successors in offset and mapped order.
    function bit trim(int n);
        bit cut;
        bit have;
        bit [63:0] best;
        cut = 0;
        have = 0;
        best = 0;
        for (int j = 0; j < erc_pkg::ENTRIES; j++) begin
            if (j == n || !ent_valid[j] || ent_off[j] <= ent_off[n]) continue;
            if (!have || ent_off[j] < best) begin
                best = ent_off[j];
                have = 1;
            end
        end
        if (have && 64'(ent_off[n]) + 64'(ent_len[n]) > best) begin
            ent_len[n] = 22'(best - ent_off[n]);
            cut = 1;
        end
        have = 0;
        for (int j = 0; j < erc_pkg::ENTRIES; j++) begin
            if (j == n || !ent_valid[j] || ent_map[j] <= ent_map[n]) continue;
            if (!have || ent_map[j] < best) begin
                best = ent_map[j];
                have = 1;
            end
        end
        if (have && 64'(ent_map[n]) + 64'(ent_len[n]) > best) begin
            ent_len[n] = 22'(best - ent_map[n]);
            cut = 1;
        end
        return cut;
    endfunction

    function erc_pkg::t_status predict_add(erc_pkg::t_in_word w, output int shown);
        int k;
        int n;
        bit [63:0] len;
        shown = -1;
        len = 64'(w.length);
        if ((w.offset & erc_pkg::ALIGN_A) != 0 || (w.length & erc_pkg::ALIGN_L) != 0 ||
            len == 0 || len > erc_pkg::MAX_LENGTH)
            return erc_pkg::ST_BAD;
        k = lookup(w.offset);
        while (k >= 0 && ent_off[k] == w.offset && len > ent_len[k] &&
               w.map_addr != ent_map[k]) begin
            drop(k);
            k = lookup(w.offset);
        end
        if (k >= 0) begin
            if (ent_off[k] != w.offset) return erc_pkg::ST_MISMATCH;
            if (len <= ent_len[k]) return erc_pkg::ST_COVERED;
            ent_len[k] = w.length;
            shown = k;
            return trim(k) ? erc_pkg::ST_TRIMMED : erc_pkg::ST_OK;
        end
        n = -1;
        for (int j = 0; j < erc_pkg::ENTRIES; j++) begin
            if (!ent_valid[j]) begin
                n = j;
                break;
            end
        end
        if (n < 0) return erc_pkg::ST_FULL;
        ent_valid[n] = 1;
        ent_off[n] = w.offset;
        ent_len[n] = w.length;
        ent_dirty[n] = w.dirty_flag;
        ent_map[n] = w.map_addr;
        live_count++;
        // Evict every other extent whose mapped range holds the new address.
        for (int j = 0; j < erc_pkg::ENTRIES; j++) begin
            if (j != n && ent_valid[j] && ent_map[j] <= w.map_addr &&
                {16'd0, w.map_addr} < 64'(ent_map[j]) + 64'(ent_len[j]))
                drop(j);
        end
        shown = n;
        return trim(n) ? erc_pkg::ST_TRIMMED : erc_pkg::ST_OK;
    endfunction

    // Note an accepted input word and queue the output word it causes.
    function void note_input(erc_pkg::t_in_word w);
        erc_pkg::t_out_word o;
        erc_pkg::t_status st;
        int k;
        st = erc_pkg::ST_OK;
        k = -1;
        case (w.action)
            erc_pkg::ACT_FIND: begin
                k = lookup(w.offset);
                st = (k >= 0) ? erc_pkg::ST_OK : erc_pkg::ST_MISS;
            end
            erc_pkg::ACT_ADD: st = predict_add(w, k);
            erc_pkg::ACT_REMOVE: begin
                k = lookup(w.offset);
                st = (k >= 0) ? erc_pkg::ST_OK : erc_pkg::ST_MISS;
                if (k >= 0) drop(k);
                k = -1;
            end
            erc_pkg::ACT_FIRST: begin
                for (int i = 0; i < erc_pkg::ENTRIES; i++)
                    if (ent_valid[i] && (k < 0 || ent_off[i] < ent_off[k])) k = i;
                st = (k >= 0) ? erc_pkg::ST_OK : erc_pkg::ST_MISS;
            end
            erc_pkg::ACT_CLEAR: begin
                for (int i = 0; i < erc_pkg::ENTRIES; i++) ent_valid[i] = 0;
                live_count = 0;
            end
            default: ;
        endcase
        o = '0;
        o.status = st;
        if (k >= 0) begin
            o.out_offset = ent_off[k];
            o.out_length = ent_len[k];
            o.out_dirty = ent_dirty[k];
            o.out_map_addr = ent_map[k];
        end
        o.extent_count = 5'(live_count);
        pending_words.push_back(o);
    endfunction

    // Compare an accepted output word with the oldest expectation.
    function void check_output(erc_pkg::t_out_word got);
        erc_pkg::t_out_word exp_w;
        if (pending_words.size() == 0) begin
            $error("unexpected output word %h", got);
            errors++;
            return;
        end
        exp_w = pending_words.pop_front();
        if (got.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, got.status);
            errors++;
        end
        if (got.out_offset !== exp_w.out_offset) begin
            $error("out_offset: expected %h, got %h", exp_w.out_offset, got.out_offset);
            errors++;
        end
        if (got.out_length !== exp_w.out_length) begin
            $error("out_length: expected %h, got %h", exp_w.out_length, got.out_length);
            errors++;
        end
        if (got.out_dirty !== exp_w.out_dirty) begin
            $error("out_dirty: expected %b, got %b", exp_w.out_dirty, got.out_dirty);
            errors++;
        end
        if (got.out_map_addr !== exp_w.out_map_addr) begin
            $error("out_map_addr: expected %h, got %h", exp_w.out_map_addr,
                   got.out_map_addr);
            errors++;
        end
        if (got.extent_count !== exp_w.extent_count) begin
            $error("extent_count: expected %0d, got %0d", exp_w.extent_count,
                   got.extent_count);
            errors++;
        end
    endfunction
endclass

module tb_extent_range_cache;
    import erc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out;

    extent_scoreboard extent_board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    bit  hold_done;
    bit  sending;
    longint cycle_count;

    // Recently used offsets and mapped addresses, reused to make hits.
    bit [47:0] offset_pool[$];
    bit [47:0] map_pool[$];

    extent_range_cache u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("extent_range_cache regression: fail");
            $finish;
        end
    end

    // Output side: take words and check them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) extent_board.check_output(o_out);
    end

    // Receiver stall, changed at the falling edge.
    always @(negedge i_clk) begin
        if (hold_recv) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Long receiver hold-off, counted in its own process.
    initial begin
        hold_recv = 0;
        hold_done = 0;
        wait (sending);
        repeat (60) @(posedge i_clk);
        hold_recv = 1;
        repeat (1500) @(posedge i_clk);
        hold_recv = 0;
        hold_done = 1;
    end

    // Send one word, waiting for its acceptance. Valid drops only while idling.
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        extent_board.note_input(w);
        @(negedge i_clk);
    endtask

    function automatic t_in_word make_word(bit [2:0] act, bit [47:0] off,
                                           bit [21:0] len, bit d, bit [47:0] map);
        t_in_word w;
        w.action = act;
        w.offset = off;
        w.length = len;
        w.dirty_flag = d;
        w.map_addr = map;
        return w;
    endfunction

    // Random word, mostly well-formed adds and lookups near earlier extents.
    function automatic t_in_word random_word();
        t_in_word w;
        int r;
        bit [47:0] off;
        bit [47:0] map;
        bit [21:0] len;
        r = $urandom_range(99);
        off = (offset_pool.size() > 0 && $urandom_range(2) != 0)
            ? offset_pool[$urandom_range(offset_pool.size() - 1)]
            : {$urandom_range(255), 12'd0};
        if ($urandom_range(3) == 0) off = {$urandom, $urandom} & 48'hffff_ffff_f000;
        off = off + 48'({$urandom_range(3), 12'd0});
        map = (map_pool.size() > 0 && $urandom_range(1) != 0)
            ? map_pool[$urandom_range(map_pool.size() - 1)] + 48'({$urandom_range(3), 12'd0})
            : {$urandom_range(1023), 12'd0} | 48'h8000_0000_0000 * $urandom_range(1);
        len = 22'({$urandom_range(8) + 1, 12'd0});
        if ($urandom_range(19) == 0) len = 22'(MAX_LENGTH);
        w = make_word(ACT_ADD, off, len, $urandom_range(1), map);
        if (r < 3) begin
            w = make_word(3'($urandom_range(7)), {$urandom, $urandom}, 22'($urandom),
                          $urandom_range(1), {$urandom, $urandom});
        end else if (r < 8) begin
            w.length = 22'($urandom);
            if ($urandom_range(1)) w.offset[11:0] = 12'($urandom);
        end else if (r < 50) begin
            w.action = ACT_ADD;
        end else if (r < 72) begin
            w.action = ACT_FIND;
            w.offset = off + 48'($urandom_range(8191));
        end else if (r < 84) begin
            w.action = ACT_REMOVE;
            w.offset = off + 48'($urandom_range(4095));
        end else if (r < 96) begin
            w.action = ACT_FIRST;
        end else begin
            w.action = ACT_CLEAR;
        end
        if (w.action == ACT_ADD) begin
            offset_pool.push_back(w.offset);
            map_pool.push_back(w.map_addr);
            if (offset_pool.size() > 24) void'(offset_pool.pop_front());
            if (map_pool.size() > 24) void'(map_pool.pop_front());
        end
        return w;
    endfunction

    initial begin
        extent_board = new();
        cycle_count = 0;
        sending = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sending = 1;

        // Directed words: empty table, extremes, every action and special case.
        send_word(make_word(ACT_FIND, 48'h0, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_FIRST, 48'h0, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_REMOVE, 48'hffff_ffff_ffff, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_ADD, 48'h1001, 22'h1000, 1'b0, 48'h0));
        send_word(make_word(ACT_ADD, 48'h1000, 22'h1001, 1'b0, 48'h0));
        send_word(make_word(ACT_ADD, 48'h1000, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_ADD, 48'h1000, 22'h201000, 1'b0, 48'h0));
        send_word(make_word(ACT_ADD, 48'h1000, 22'h3f_ffff, 1'b1, 48'hffff_ffff_ffff));
        send_word(make_word(ACT_ADD, 48'h0, 22'(MAX_LENGTH), 1'b1, 48'h10_0000));
        send_word(make_word(ACT_ADD, 48'h0, 22'h1000, 1'b0, 48'h10_0000));
        send_word(make_word(ACT_ADD, 48'h1000, 22'h2000, 1'b0, 48'h10_1000));
        send_word(make_word(ACT_ADD, 48'h8000_0000, 22'h2000, 1'b0, 48'h10_0000));
        send_word(make_word(ACT_ADD, 48'h8000_0000, 22'h4000, 1'b1, 48'h10_0000));
        send_word(make_word(ACT_ADD, 48'h8000_0000, 22'h8000, 1'b0, 48'h50_0000));
        send_word(make_word(ACT_ADD, 48'hffff_ffff_f000, 22'h1000, 1'b1,
                            48'hffff_ffff_f000));
        send_word(make_word(ACT_ADD, 48'h4000, 22'h4000, 1'b0, 48'h4f_f000));
        send_word(make_word(ACT_FIND, 48'h8000_7fff, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_FIND, 48'hffff_ffff_ffff, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_FIRST, 48'h0, 22'h0, 1'b0, 48'h0));
        send_word(make_word(ACT_REMOVE, 48'h4000, 22'h0, 1'b0, 48'h0));
        send_word(make_word(3'd5, 48'h1000, 22'h1000, 1'b1, 48'h0));
        send_word(make_word(3'd7, 48'h0, 22'h0, 1'b0, 48'h0));
        // Fill the table past its size.
        for (int i = 0; i < 18; i++)
            send_word(make_word(ACT_ADD, 48'({i, 20'h0}) + 48'h1_0000_0000, 22'h2000,
                                i[0], 48'({i, 20'h0}) + 48'h2_0000_0000));
        send_word(make_word(ACT_CLEAR, 48'h0, 22'h0, 1'b0, 48'h0));

        // Random words in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 27 : 0;
            for (int n = 0; n < 280; n++) send_word(random_word());
        end
        i_in_valid <= 1'b0;

        wait (hold_done);
        while (extent_board.pending_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (extent_board.errors == 0 && extent_board.pending_words.size() == 0)
            $display("extent_range_cache regression: pass");
        else
            $display("extent_range_cache regression: fail");
        $finish;
    end
endmodule
